[src/s2lab_pkg.sv]
// s2lab_pkg: shared types and constants for the sRGB to CIE L*a*b* converter.
// Holds the pixel and result structs, the sRGB-to-XYZ mix and the D65 white point.
// No dependencies.
`default_nettype none

package s2lab_pkg;

    // Default configuration
    localparam int CUBE_ENTRIES_DEF = 4096;
    localparam int FRAC_BITS_DEF    = 16;

    // Channel order for X, Y, Z lanes
    localparam int CH_X = 0;
    localparam int CH_Y = 1;
    localparam int CH_Z = 2;

    // Mixing coefficients in millionths, rows X, Y, Z; columns R, G, B
    localparam int COEF_W = 20;
    localparam logic [COEF_W-1:0] MIX_COEF [3][3] = '{
        '{20'd412453, 20'd357580, 20'd180423},
        '{20'd212671, 20'd715160, 20'd72169},
        '{20'd19334,  20'd119193, 20'd950227}
    };

    // White point divisors in millionths
    localparam int DEN_W = 21;
    localparam logic [DEN_W-1:0] DEN_X = 21'd950470;
    localparam logic [DEN_W-1:0] DEN_Y = 21'd1000000;
    localparam logic [DEN_W-1:0] DEN_Z = 21'd1088830;

    // Q30 helpers for building the ROMs
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned LN2_Q30 = 64'd744261118;

    // Input transaction: gamma-encoded sRGB
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    // Result transaction: L*, a*, b* in 1/256 units
    typedef struct packed {
        logic        [14:0] lightness;
        logic signed [15:0] a_star;
        logic signed [15:0] b_star;
    } t_lab;

endpackage

`default_nettype wire

[src/srgb_to_cielab_lut.sv]
// srgb_to_cielab_lut: sRGB (8 bits per channel) to CIE L*a*b* (D65), 12-stage pipeline.
// o_strobe is the valid bit of stage 12, in step with o_lab. Throughput: one pixel every cycle;
// busy stays low because every stage advances each cycle and the receiver cannot stall.
// Reset (i_rst_n, synchronous, active low) clears only the stage valid bits; the gamma
// and cube-root ROMs are constants built at elaboration, so no clearing pass is needed.
// Depends on s2lab_pkg.
`default_nettype none

module srgb_to_cielab_lut #(
    parameter int CUBE_TABLE_ENTRIES = s2lab_pkg::CUBE_ENTRIES_DEF,
    parameter int FRAC_BITS          = s2lab_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire s2lab_pkg::t_pixel  i_pixel,
    output logic                    o_strobe,
    output s2lab_pkg::t_lab         o_lab
);
    import s2lab_pkg::*;

    // Widths
    localparam int GW    = FRAC_BITS + 1;                 // gamma entry
    localparam int SW    = FRAC_BITS + 21;                // mixed sum
    localparam int SLW   = SW / 2;
    localparam int SHW   = SW - SLW;
    localparam int NW    = $clog2(CUBE_TABLE_ENTRIES + 1);
    localparam int MW    = SW + NW;                       // sum times table size
    localparam int TW    = MW - FRAC_BITS;                // scaled sum, integer part
    localparam int TLW   = TW / 2;
    localparam int THW   = TW - TLW;
    localparam int RW    = TW - 19;                       // reciprocal width
    localparam int QW    = TW - 19;                       // quotient estimate width
    localparam int PW    = QW + DEN_W;                    // quotient times divisor
    localparam int IW    = $clog2(CUBE_TABLE_ENTRIES);
    localparam int CW    = FRAC_BITS + 1;                 // cube entry
    localparam int AW    = FRAC_BITS + 11;                // signed L/a/b before clamp
    localparam int DEPTH = 12;

    localparam longint unsigned NENT = CUBE_TABLE_ENTRIES;

    // Linear cube segment: rounding offset and divisor for 7.787 v
    localparam longint unsigned CUBE_LIN_OFS = 64'd58000 * NENT;
    localparam longint unsigned CUBE_LIN_DEN = 64'd116000 * NENT;

    // Result lanes
    localparam int LAB_L = 0;
    localparam int LAB_A = 1;
    localparam int LAB_B = 2;

    localparam logic [NW-1:0]    NMUL = NW'(CUBE_TABLE_ENTRIES);
    localparam logic [QW-1:0]    QMAX = QW'(CUBE_TABLE_ENTRIES - 1);
    localparam logic [IW-1:0]    IMAX = IW'(CUBE_TABLE_ENTRIES - 1);
    localparam logic [DEN_W-1:0] DEN [3] = '{DEN_X, DEN_Y, DEN_Z};

    // floor(2^TW / D): estimate is low by at most one since T < 2^TW
    localparam logic [RW-1:0] RECIP [3] = '{
        RW'((64'd1 << TW) / DEN_X),
        RW'((64'd1 << TW) / DEN_Y),
        RW'((64'd1 << TW) / DEN_Z)
    };

    // Output formatting constants
    localparam logic signed [AW-1:0] K116   = AW'(116);
    localparam logic signed [AW-1:0] K500   = AW'(500);
    localparam logic signed [AW-1:0] K200   = AW'(200);
    localparam logic signed [AW-1:0] L_OFS  = AW'(16) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] L_HI   = AW'(100) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] AB_LIM = AW'(120) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] ZERO   = '0;
    localparam logic signed [AW-1:0] RND    = AW'(1) <<< (FRAC_BITS - 9);

    typedef logic [GW-1:0] t_gamma_rom [256];
    typedef logic [CW-1:0] t_cube_rom  [CUBE_TABLE_ENTRIES];

    // ---------------------------------------------------------------
    // ROM builders (elaboration only)
    // ---------------------------------------------------------------
    function automatic longint unsigned pow5_q30(input longint unsigned y);
        longint unsigned y2, y4;
        y2 = (y * y) >> 30;
        y4 = (y2 * y2) >> 30;
        return (y4 * y) >> 30;
    endfunction

    function automatic longint unsigned pow3_q30(input longint unsigned y);
        return (((y * y) >> 30) * y) >> 30;
    endfunction

    // -log2(x) in Q30, x in Q30 below one
    function automatic longint unsigned neglog2_q30(input longint unsigned x);
        longint unsigned s, m, fr;
        s  = 0;
        m  = x;
        fr = 0;
        for (int k = 0; k < 31; k++) begin
            if (m < Q30_ONE) begin
                m = m << 1;
                s = s + 1;
            end
        end
        for (int k = 0; k < 30; k++) begin
            m  = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (Q30_ONE << 1)) begin
                m  = m >> 1;
                fr = fr | 64'd1;
            end
        end
        return (s << 30) - fr;
    endfunction

    function automatic longint unsigned to_frac(input longint unsigned q30);
        return (q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    endfunction

    function automatic t_gamma_rom build_gamma();
        t_gamma_rom      rom;
        longint unsigned t, u, r, cand, ii;
        for (int i = 0; i < 256; i++) begin
            ii = 64'(i);
            if (ii * 64'd100000 > 64'd1031475) begin
                t = ((64'd1000 * ii + 64'd14025) << 30) / 64'd269025;
                u = (t * t) >> 30;
                r = 0;
                for (int b = 30; b >= 0; b--) begin
                    cand = r | (64'd1 << b);
                    if (cand <= Q30_ONE) begin
                        if (pow5_q30(cand) <= u) begin
                            r = cand;
                        end
                    end
                end
                rom[i] = GW'(to_frac((u * r) >> 30));
            end else begin
                rom[i] = GW'((ii * 64'd100 * (64'd1 << FRAC_BITS) + 64'd164730)
                             / 64'd329460);
            end
        end
        return rom;
    endfunction

    function automatic t_cube_rom build_cube();
        t_cube_rom       rom;
        longint unsigned v, c, l, d, cand, ii;
        for (int i = 0; i < CUBE_TABLE_ENTRIES; i++) begin
            ii = 64'(i);
            if (ii * 64'd1000000 > 64'd8856 * NENT) begin
                v = (ii << 30) / NENT;
                c = 0;
                for (int b = 30; b >= 0; b--) begin
                    cand = c | (64'd1 << b);
                    if (cand <= Q30_ONE) begin
                        if (pow3_q30(cand) <= v) begin
                            c = cand;
                        end
                    end
                end
                l = neglog2_q30(v);
                d = (((l >> 3) * LN2_Q30) >> 27) / 64'd30000;
                rom[i] = CW'(to_frac(c + ((c * d) >> 30)));
            end else begin
                rom[i] = CW'((64'd903292 * ii * (64'd1 << FRAC_BITS) + CUBE_LIN_OFS)
                             / CUBE_LIN_DEN);
            end
        end
        return rom;
    endfunction

    localparam t_gamma_rom GAMMA_ROM = build_gamma();
    localparam t_cube_rom  CUBE_ROM  = build_cube();

    // Clamp to [lo, hi] and round half up to 1/256 units
    function automatic logic signed [AW-1:0] clamp_round(
        input logic signed [AW-1:0] v,
        input logic signed [AW-1:0] lo,
        input logic signed [AW-1:0] hi
    );
        logic signed [AW-1:0] cl;
        cl = v;
        if (v < lo) begin
            cl = lo;
        end
        if (v > hi) begin
            cl = hi;
        end
        return (cl + RND) >>> (FRAC_BITS - 8);
    endfunction

    // ---------------------------------------------------------------
    // Pipeline registers
    // ---------------------------------------------------------------
    logic [DEPTH-1:0]        r_vld, n_vld;
    logic [GW-1:0]           r_gam  [3];                // stage 1
    logic [SW-1:0]           r_prod [3][3];             // stage 2
    logic [SW-1:0]           r_sum  [3], n_sum [3];     // stage 3
    logic [SLW+NW-1:0]       r_plo  [3];                // stage 4
    logic [SHW+NW-1:0]       r_phi  [3];
    logic [TW-1:0]           r_t5   [3], n_t5 [3];      // stage 5
    logic [TLW+RW-1:0]       r_rlo  [3];                // stage 6
    logic [THW+RW-1:0]       r_rhi  [3];
    logic [TW-1:0]           r_t6   [3];
    logic [QW-1:0]           r_qe7  [3], n_qe7 [3];     // stage 7
    logic [TW-1:0]           r_t7   [3];
    logic [PW-1:0]           r_p8   [3];                // stage 8
    logic [QW-1:0]           r_qe8  [3];
    logic [TW-1:0]           r_t8   [3];
    logic [IW-1:0]           r_idx  [3], n_idx [3];     // stage 9
    logic [CW-1:0]           r_cube [3];                // stage 10
    logic signed [AW-1:0]    r_lab  [3], n_lab [3];     // stage 11
    t_lab                    r_out, n_out;              // stage 12

    // Combinational temporaries
    logic [MW-1:0]           m_full [3];
    logic [TW+RW-1:0]        m_rfull [3];
    logic [PW-1:0]           diff   [3];
    logic [QW-1:0]           q_fix  [3];
    logic signed [AW-1:0]    cx, cy, cz, dxy, dyz;
    logic signed [AW-1:0]    rnd    [3];

    // No stall anywhere: always ready
    assign busy = 1'b0;

    // Valid bits travel with the data
    assign n_vld = {r_vld[DEPTH-2:0], start & ~busy};

    // ---------------------------------------------------------------
    // Next-value logic
    // ---------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            // stage 3: sum of three mix products
            n_sum[c]  = r_prod[c][0] + r_prod[c][1] + r_prod[c][2];

            // stage 5: T = floor(S * N / 2^F)
            m_full[c] = {r_phi[c], {SLW{1'b0}}} + MW'(r_plo[c]);
            n_t5[c]   = m_full[c][MW-1:FRAC_BITS];

            // stage 7: quotient estimate floor(T * R / 2^TW)
            m_rfull[c] = {r_rhi[c], {TLW{1'b0}}} + (TW+RW)'(r_rlo[c]);
            n_qe7[c]   = m_rfull[c][TW+RW-1:TW];

            // stage 9: correct by one, saturate to last entry
            diff[c]   = PW'(r_t8[c]) - r_p8[c];
            q_fix[c]  = r_qe8[c] + QW'(diff[c] >= PW'(DEN[c]));
            if (q_fix[c] > QMAX) begin
                n_idx[c] = IMAX;
            end else begin
                n_idx[c] = q_fix[c][IW-1:0];
            end
        end

        // stage 11: L = 116 cy - 16, a = 500 (cx - cy), b = 200 (cy - cz)
        cx  = $signed(AW'(r_cube[CH_X]));
        cy  = $signed(AW'(r_cube[CH_Y]));
        cz  = $signed(AW'(r_cube[CH_Z]));
        dxy = cx - cy;
        dyz = cy - cz;
        n_lab[LAB_L] = cy * K116 - L_OFS;
        n_lab[LAB_A] = dxy * K500;
        n_lab[LAB_B] = dyz * K200;

        // stage 12: clamp and round to 1/256 units
        rnd[LAB_L] = clamp_round(r_lab[LAB_L], ZERO, L_HI);
        rnd[LAB_A] = clamp_round(r_lab[LAB_A], -AB_LIM, AB_LIM);
        rnd[LAB_B] = clamp_round(r_lab[LAB_B], -AB_LIM, AB_LIM);
        n_out.lightness = rnd[LAB_L][14:0];
        n_out.a_star    = rnd[LAB_A][15:0];
        n_out.b_star    = rnd[LAB_B][15:0];
    end

    // ---------------------------------------------------------------
    // Stage registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // control: only the valid bits are reset
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end

        // stage 1: gamma linearization
        r_gam[0] <= GAMMA_ROM[i_pixel.red];
        r_gam[1] <= GAMMA_ROM[i_pixel.green];
        r_gam[2] <= GAMMA_ROM[i_pixel.blue];

        for (int c = 0; c < 3; c++) begin
            // stage 2: matrix products
            for (int k = 0; k < 3; k++) begin
                r_prod[c][k] <= r_gam[k] * MIX_COEF[c][k];
            end
            // stage 3
            r_sum[c]  <= n_sum[c];
            // stage 4: S * N split in two partial products
            r_plo[c]  <= r_sum[c][SLW-1:0] * NMUL;
            r_phi[c]  <= r_sum[c][SW-1:SLW] * NMUL;
            // stage 5
            r_t5[c]   <= n_t5[c];
            // stage 6: T * reciprocal split in two partial products
            r_rlo[c]  <= r_t5[c][TLW-1:0] * RECIP[c];
            r_rhi[c]  <= r_t5[c][TW-1:TLW] * RECIP[c];
            r_t6[c]   <= r_t5[c];
            // stage 7
            r_qe7[c]  <= n_qe7[c];
            r_t7[c]   <= r_t6[c];
            // stage 8: back-multiply for the remainder check
            r_p8[c]   <= r_qe7[c] * DEN[c];
            r_qe8[c]  <= r_qe7[c];
            r_t8[c]   <= r_t7[c];
            // stage 9
            r_idx[c]  <= n_idx[c];
            // stage 10: cube-root ROM read, one copy per lane
            r_cube[c] <= CUBE_ROM[r_idx[c]];
            // stage 11
            r_lab[c]  <= n_lab[c];
        end

        // stage 12
        r_out <= n_out;
    end

    assign o_strobe = r_vld[DEPTH-1];
    assign o_lab    = r_out;

endmodule

`default_nettype wire
